// ===== hdl/rotate_x_perspective_project_top_defines.svh =====
// Assertion macros for the rotate / project block.
// Needs clk and rst in the scope where a macro is used.
`ifndef ROTATE_X_PERSPECTIVE_PROJECT_TOP_DEFINES_SVH
`define ROTATE_X_PERSPECTIVE_PROJECT_TOP_DEFINES_SVH

// same-cycle implication
`define RXPP_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("rxpp assertion failed");

// next-cycle implication
`define RXPP_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("rxpp assertion failed");

`endif

// ===== hdl/rxpp_pkg.sv =====
// Shared types, register codes and width helpers for the rotate / project block.
// No dependencies.
package rxpp_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int QUO_W         = 18;  // 17 quotient bits plus overflow bit
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 17;

  localparam logic [CFG_IDX_W-1:0] REG_COS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CX     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CY     = 3'd5;

  localparam logic signed [15:0] COS_RESET    = 16'sd16384;
  localparam logic signed [15:0] SIN_RESET    = 16'sd0;
  localparam logic [16:0]        CAMERA_RESET = 17'd49152;
  localparam logic [7:0]         FOCAL_RESET  = 8'd34;
  localparam logic [7:0]         CX_RESET     = 8'd64;
  localparam logic [7:0]         CY_RESET     = 8'd32;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               proj_valid;
  } screen_t;

  typedef struct packed {
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
    logic [16:0]        camera_distance;
    logic [7:0]         focal_scale;
    logic [7:0]         center_x;
    logic [7:0]         center_y;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic proj_ok;
    logic neg_x;
    logic neg_y;
  } ctrl_t;

  // magnitude width of a positive depth
  function automatic int den_width(input int f);
    return ((f + 17 > 32) ? f + 17 : 32) + 1;
  endfunction

  // magnitude width of the numerators
  function automatic int num_width(input int f);
    return (f + 23 > 39) ? f + 23 : 39;
  endfunction

  function automatic int cmp_width(input int f);
    return (num_width(f) > den_width(f) + QUO_W - 1) ?
           num_width(f) : den_width(f) + QUO_W - 1;
  endfunction

endpackage

// ===== hdl/rotate_x_perspective_project_top.sv =====
// Throughput: one word per cycle; 4 rotate/depth stages, an 18-cell quotient
// chain (one bit per cell for x and y), one finish stage and the output register.
// Input stalls only while the skid word behind a held output is occupied.
// Reset (synchronous, rst high): empties the pipeline, loads register defaults.
// Depends on rxpp_pkg, rxpp_rotate, rxpp_div_cell, rxpp_out and the defines header.
`include "rotate_x_perspective_project_top_defines.svh"

module rotate_x_perspective_project_top #(
  parameter int FRAC_BITS = rxpp_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            point_valid,
  output logic                            point_ready,
  input  rxpp_pkg::point_t                point,
  output logic                            screen_valid,
  input  logic                            screen_ready,
  output rxpp_pkg::screen_t               screen,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rxpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rxpp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rxpp_pkg::*;

  localparam int DEN_W = den_width(FRAC_BITS);
  localparam int NUM_W = num_width(FRAC_BITS);

  cfg_t             cfg;
  logic             en;
  ctrl_t            chain_ctrl  [QUO_W+1];
  logic [DEN_W-1:0] chain_den   [QUO_W+1];
  logic [NUM_W-1:0] chain_rem_x [QUO_W+1];
  logic [NUM_W-1:0] chain_rem_y [QUO_W+1];
  logic [QUO_W-1:0] chain_quo_x [QUO_W+1];
  logic [QUO_W-1:0] chain_quo_y [QUO_W+1];

  assign cfg_ready   = 1'b1;
  assign point_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_angle       <= COS_RESET;
      cfg.sin_angle       <= SIN_RESET;
      cfg.camera_distance <= CAMERA_RESET;
      cfg.focal_scale     <= FOCAL_RESET;
      cfg.center_x        <= CX_RESET;
      cfg.center_y        <= CY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COS:    cfg.cos_angle       <= cfg_data[15:0];
        REG_SIN:    cfg.sin_angle       <= cfg_data[15:0];
        REG_CAMERA: cfg.camera_distance <= cfg_data[16:0];
        REG_FOCAL:  cfg.focal_scale     <= cfg_data[7:0];
        REG_CX:     cfg.center_x        <= cfg_data[7:0];
        REG_CY:     cfg.center_y        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rxpp_rotate #(.FRAC_BITS(FRAC_BITS)) u_rotate (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .take  (point_valid && point_ready),
    .point (point),
    .cfg   (cfg),
    .ctrl  (chain_ctrl[0]),
    .den   (chain_den[0]),
    .mag_x (chain_rem_x[0]),
    .mag_y (chain_rem_y[0])
  );

  assign chain_quo_x[0] = '0;
  assign chain_quo_y[0] = '0;

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    rxpp_div_cell #(
      .FRAC_BITS (FRAC_BITS),
      .STEP      (QUO_W - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .ctrl_in   (chain_ctrl[i]),
      .den_in    (chain_den[i]),
      .rem_x_in  (chain_rem_x[i]),
      .rem_y_in  (chain_rem_y[i]),
      .quo_x_in  (chain_quo_x[i]),
      .quo_y_in  (chain_quo_y[i]),
      .ctrl_out  (chain_ctrl[i+1]),
      .den_out   (chain_den[i+1]),
      .rem_x_out (chain_rem_x[i+1]),
      .rem_y_out (chain_rem_y[i+1]),
      .quo_x_out (chain_quo_x[i+1]),
      .quo_y_out (chain_quo_y[i+1])
    );
  end

  rxpp_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (chain_ctrl[QUO_W]),
    .rem_x        (chain_rem_x[QUO_W]),
    .rem_y        (chain_rem_y[QUO_W]),
    .quo_x        (chain_quo_x[QUO_W]),
    .quo_y        (chain_quo_y[QUO_W]),
    .cfg          (cfg),
    .en           (en),
    .screen_valid (screen_valid),
    .screen_ready (screen_ready),
    .screen       (screen)
  );

  // skid word is only held behind a held output word
  `RXPP_ASSERT_NOW(a_skid_needs_out, !en, screen_valid)
  // a stall freezes the end of the quotient chain
  `RXPP_ASSERT_NEXT(a_stall_holds_chain, !en, chain_ctrl[QUO_W] == $past(chain_ctrl[QUO_W]))
  // no positive depth gives zero coordinates
  `RXPP_ASSERT_NOW(a_invalid_is_zero, screen_valid && !screen.proj_valid,
                   screen.screen_x == 16'sd0 && screen.screen_y == 16'sd0)

endmodule

// ===== hdl/rxpp_rotate.sv =====
// Front end: X-axis rotation, depth, numerators and their magnitudes (4 stages).
// Depends on rxpp_pkg.
module rxpp_rotate #(
  parameter int  FRAC_BITS = rxpp_pkg::FRAC_BITS_DEF,
  localparam int DEN_W     = rxpp_pkg::den_width(FRAC_BITS),
  localparam int NUM_W     = rxpp_pkg::num_width(FRAC_BITS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              take,
  input  rxpp_pkg::point_t  point,
  input  rxpp_pkg::cfg_t    cfg,
  output rxpp_pkg::ctrl_t   ctrl,
  output logic [DEN_W-1:0]  den,
  output logic [NUM_W-1:0]  mag_x,
  output logic [NUM_W-1:0]  mag_y
);
  import rxpp_pkg::*;

  localparam int DEPTH_W = DEN_W + 1;
  localparam int XF_W    = 24;  // |x * f| < 2^23
  localparam int NY_W    = 40;  // |y1 * f| < 2^39

  logic                 v1, v2, v3, v4;
  logic signed [31:0]   ycos, zsin, ysin, zcos;
  logic signed [24:0]   xf_full;
  logic [XF_W-1:0]      xf1, xf2, xf3;
  logic [32:0]          y1, z1;
  logic [DEPTH_W-1:0]   depth;
  logic signed [41:0]   ny_full;
  logic [NY_W-1:0]      ny;
  logic [XF_W-1:0]      xf_neg;
  logic [NY_W-1:0]      ny_neg;
  logic [XF_W-2:0]      x_abs;
  logic [NY_W-2:0]      y_abs;
  logic                 ok4, nx4, ny4;

  assign xf_full = point.point_x * $signed({1'b0, cfg.focal_scale});
  assign ny_full = $signed(y1) * $signed({1'b0, cfg.focal_scale});
  assign xf_neg  = -xf3;
  assign ny_neg  = -ny;
  assign x_abs   = xf3[XF_W-1] ? xf_neg[XF_W-2:0] : xf3[XF_W-2:0];
  assign y_abs   = ny[NY_W-1] ? ny_neg[NY_W-2:0] : ny[NY_W-2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ycos  <= point.point_y * cfg.cos_angle;
      zsin  <= point.point_z * cfg.sin_angle;
      ysin  <= point.point_y * cfg.sin_angle;
      zcos  <= point.point_z * cfg.cos_angle;
      xf1   <= xf_full[XF_W-1:0];
      y1    <= {ycos[31], ycos} - {zsin[31], zsin};
      z1    <= {ysin[31], ysin} + {zcos[31], zcos};
      xf2   <= xf1;
      depth <= DEPTH_W'($signed(z1))
             + DEPTH_W'({cfg.camera_distance, {FRAC_BITS{1'b0}}});
      ny    <= ny_full[NY_W-1:0];
      xf3   <= xf2;
      den   <= depth[DEN_W-1:0];
      ok4   <= !depth[DEPTH_W-1] && (|depth);
      nx4   <= xf3[XF_W-1];
      ny4   <= ny[NY_W-1];
      mag_x <= NUM_W'(x_abs) << FRAC_BITS;
      mag_y <= NUM_W'(y_abs);
    end
  end

  assign ctrl = '{valid: v4, proj_ok: ok4, neg_x: nx4, neg_y: ny4};

endmodule

// ===== hdl/rxpp_div_cell.sv =====
// One restoring-division cell: one quotient bit for both x and y numerators.
// Depends on rxpp_pkg.
module rxpp_div_cell #(
  parameter int  FRAC_BITS = rxpp_pkg::FRAC_BITS_DEF,
  parameter int  STEP      = rxpp_pkg::QUO_W - 1,
  localparam int DEN_W     = rxpp_pkg::den_width(FRAC_BITS),
  localparam int NUM_W     = rxpp_pkg::num_width(FRAC_BITS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  rxpp_pkg::ctrl_t            ctrl_in,
  input  logic [DEN_W-1:0]           den_in,
  input  logic [NUM_W-1:0]           rem_x_in,
  input  logic [NUM_W-1:0]           rem_y_in,
  input  logic [rxpp_pkg::QUO_W-1:0] quo_x_in,
  input  logic [rxpp_pkg::QUO_W-1:0] quo_y_in,
  output rxpp_pkg::ctrl_t            ctrl_out,
  output logic [DEN_W-1:0]           den_out,
  output logic [NUM_W-1:0]           rem_x_out,
  output logic [NUM_W-1:0]           rem_y_out,
  output logic [rxpp_pkg::QUO_W-1:0] quo_x_out,
  output logic [rxpp_pkg::QUO_W-1:0] quo_y_out
);
  import rxpp_pkg::*;

  localparam int CMP_W = cmp_width(FRAC_BITS);

  logic [CMP_W-1:0] sub_den, diff_x, diff_y;
  logic             fit_x, fit_y;
  logic             valid;
  ctrl_t            ctrl_q;

  assign sub_den = CMP_W'(den_in) << STEP;
  assign diff_x  = CMP_W'(rem_x_in) - sub_den;
  assign diff_y  = CMP_W'(rem_y_in) - sub_den;
  assign fit_x   = CMP_W'(rem_x_in) >= sub_den;
  assign fit_y   = CMP_W'(rem_y_in) >= sub_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= ctrl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_q    <= ctrl_in;
      den_out   <= den_in;
      rem_x_out <= fit_x ? diff_x[NUM_W-1:0] : rem_x_in;
      rem_y_out <= fit_y ? diff_y[NUM_W-1:0] : rem_y_in;
      quo_x_out <= {quo_x_in[QUO_W-2:0], fit_x};
      quo_y_out <= {quo_y_in[QUO_W-2:0], fit_y};
    end
  end

  always_comb begin
    ctrl_out       = ctrl_q;
    ctrl_out.valid = valid;
  end

endmodule

// ===== hdl/rxpp_out.sv =====
// Truncation, center offset and saturation stage, then output register with skid word.
// Depends on rxpp_pkg.
module rxpp_out #(
  parameter int  FRAC_BITS = rxpp_pkg::FRAC_BITS_DEF,
  localparam int NUM_W     = rxpp_pkg::num_width(FRAC_BITS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rxpp_pkg::ctrl_t            ctrl,
  input  logic [NUM_W-1:0]           rem_x,
  input  logic [NUM_W-1:0]           rem_y,
  input  logic [rxpp_pkg::QUO_W-1:0] quo_x,
  input  logic [rxpp_pkg::QUO_W-1:0] quo_y,
  input  rxpp_pkg::cfg_t             cfg,
  output logic                       en,
  output logic                       screen_valid,
  input  logic                       screen_ready,
  output rxpp_pkg::screen_t          screen
);
  import rxpp_pkg::*;

  localparam logic [15:0] SAT_MAX = 16'h7fff;
  localparam logic [15:0] SAT_MIN = 16'h8000;

  // quo holds floor(|num| / den) with the top bit flagging overflow
  function automatic logic [15:0] finish(input logic [QUO_W-1:0] quo,
                                         input logic             rem_nz,
                                         input logic             neg,
                                         input logic [7:0]       ctr);
    logic [QUO_W-2:0]        q;
    logic [QUO_W-1:0]        sum;
    logic signed [QUO_W:0]   diff;
    logic                    adj;
    logic [15:0]             res;
    q    = quo[QUO_W-2:0];
    adj  = rem_nz && (QUO_W'(ctr) > QUO_W'(q));
    sum  = QUO_W'(q) + QUO_W'(ctr);
    diff = (QUO_W+1)'(ctr) - (QUO_W+1)'(q) - (QUO_W+1)'(adj);
    if (!neg) begin
      res = (quo[QUO_W-1] || sum > QUO_W'(SAT_MAX)) ? SAT_MAX : sum[15:0];
    end else begin
      res = (quo[QUO_W-1] || diff < -32768) ? SAT_MIN : diff[15:0];
    end
    return res;
  endfunction

  logic    fin_valid, skid_full;
  screen_t fin_next, fin_word, skid_word;

  always_comb begin
    fin_next.proj_valid = ctrl.proj_ok;
    fin_next.screen_x   = '0;
    fin_next.screen_y   = '0;
    if (ctrl.proj_ok) begin
      fin_next.screen_x = finish(quo_x, |rem_x, ctrl.neg_x, cfg.center_x);
      fin_next.screen_y = finish(quo_y, |rem_y, ctrl.neg_y, cfg.center_y);
    end
  end

  assign en = !skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid    <= 1'b0;
      screen_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else begin
      if (en) begin
        fin_valid <= ctrl.valid;
      end
      if (!screen_valid || screen_ready) begin
        if (skid_full) begin
          screen_valid <= 1'b1;
          skid_full    <= 1'b0;
        end else begin
          screen_valid <= fin_valid;
        end
      end else if (fin_valid && en) begin
        skid_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_word <= fin_next;
    end
    if (!screen_valid || screen_ready) begin
      screen <= skid_full ? skid_word : fin_word;
    end else if (fin_valid && en) begin
      skid_word <= fin_word;
    end
  end

endmodule

// ===== dv/rotate_x_perspective_project_top_tb.sv =====
// Self-checking testbench for rotate_x_perspective_project_top: X-axis rotation and
// perspective divide, predicted per word and compared field by field in order.
// Depends on rxpp_pkg and the rotate_x_perspective_project_top RTL.
`timescale 1ns / 100ps

module rotate_x_perspective_project_top_tb;
  import rxpp_pkg::*;

  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  point_valid  = 1'b0;
  logic                  point_ready;
  point_t                point        = '0;
  logic                  screen_valid;
  logic                  screen_ready = 1'b0;
  screen_t               screen;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // shadow of the block's registers
  logic signed [15:0] cos_q14  = COS_RESET;
  logic signed [15:0] sin_q14  = SIN_RESET;
  logic [16:0]        cam_dist = CAMERA_RESET;
  logic [7:0]         focal_q  = FOCAL_RESET;
  logic [7:0]         ctr_x    = CX_RESET;
  logic [7:0]         ctr_y    = CY_RESET;

  screen_t pending_screens[$];
  screen_t want;
  int      mismatch_count = 0;
  int      cycle_count    = 0;
  int      idle_pct       = 0;
  int      stall_pct      = 0;
  int      hold_cycles    = 0;

  rotate_x_perspective_project_top DUT (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .point        (point),
    .screen_valid (screen_valid),
    .screen_ready (screen_ready),
    .screen       (screen),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic screen_t project_point(input point_t p);
    longint  px, py, pz, cs, sn, y_rot, z_rot, depth, f;
    screen_t r;
    px    = longint'($signed(p.point_x));
    py    = longint'($signed(p.point_y));
    pz    = longint'($signed(p.point_z));
    cs    = longint'(cos_q14);
    sn    = longint'(sin_q14);
    f     = longint'(focal_q);
    y_rot = py * cs - pz * sn;
    z_rot = py * sn + pz * cs;
    depth = z_rot + (longint'(cam_dist) << FRAC);
    r     = '0;
    if (depth > 0) begin
      r.screen_x   = clamp16((px * f * (longint'(1) << FRAC) + longint'(ctr_x) * depth) / depth);
      r.screen_y   = clamp16((y_rot * f + longint'(ctr_y) * depth) / depth);
      r.proj_valid = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(3))
      0: return 16'($urandom_range(2048)) - 16'd1024;
      1: begin
        case ($urandom_range(4))
          0: return 16'h8000;
          1: return 16'hFFFF;
          2: return 16'h0000;
          3: return 16'h0001;
          default: return 16'h7FFF;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic point_t random_point();
    point_t p;
    p.point_x = pick_coord();
    p.point_y = pick_coord();
    p.point_z = pick_coord();
    return p;
  endfunction

  // one word into the block; expectation recorded at acceptance
  task automatic send_point(input point_t p);
    int gap;
    gap = 0;
    while (gap < 200 && $urandom_range(99) < idle_pct) gap++;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_valid <= 1'b1;
    point       <= p;
    @(posedge clk);
    while (!point_ready) @(posedge clk);
    pending_screens.push_back(project_point(p));
  endtask

  // sender holds off until every expected word is back
  task automatic drain_screens();
    point_valid <= 1'b0;
    while (pending_screens.size() != 0) @(posedge clk);
  endtask

  // cfg_valid is left high; the next send_point lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_COS:    cos_q14  = data[15:0];
      REG_SIN:    sin_q14  = data[15:0];
      REG_CAMERA: cam_dist = data[16:0];
      REG_FOCAL:  focal_q  = data[7:0];
      REG_CX:     ctr_x    = data[7:0];
      REG_CY:     ctr_y    = data[7:0];
      default: ;
    endcase
  endtask

  task automatic randomize_config();
    logic [CFG_DATA_W-1:0] cv, sv, cam;
    cv  = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(32768) - 16384);
    sv  = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(32768) - 16384);
    cam = ($urandom_range(3) == 0) ? 17'($urandom_range(8192)) : 17'($urandom);
    write_reg(REG_COS, cv);
    write_reg(REG_SIN, sv);
    write_reg(REG_CAMERA, cam);
    write_reg(REG_FOCAL, 17'($urandom));
    write_reg(REG_CX, 17'($urandom));
    write_reg(REG_CY, 17'($urandom));
    if ($urandom_range(1) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, 17'($urandom));
  endtask

  task automatic test_reset_defaults();
    send_point('{16'sd0, 16'sd0, 16'sd0});
    send_point('{16'sd32767, 16'sd32767, 16'sd32767});
    send_point('{-16'sd32768, -16'sd32768, -16'sd32768});
    send_point('{16'sd32767, -16'sd32768, 16'sd0});
    send_point('{-16'sd32768, 16'sd32767, -16'sd32768});
  endtask

  // zero, negative and smallest positive depth
  task automatic test_depth_sign();
    drain_screens();
    write_reg(REG_CAMERA, 17'd0);
    send_point('{16'sd100, 16'sd100, 16'sd0});
    send_point('{16'sd100, 16'sd100, -16'sd1});
    send_point('{16'sd100, 16'sd100, 16'sd1});
  endtask

  task automatic test_saturation();
    drain_screens();
    write_reg(REG_CAMERA, 17'd1);
    write_reg(REG_FOCAL, 17'd255);
    write_reg(REG_CX, 17'd255);
    write_reg(REG_CY, 17'd0);
    send_point('{16'sd32767, 16'sd32767, 16'sd0});
    send_point('{-16'sd32768, -16'sd32768, 16'sd0});
  endtask

  // rotation terms beyond unity, largest camera distance, zero and unit focal scale, center extremes, negative sine
  task automatic test_register_extremes();
    drain_screens();
    write_reg(REG_COS, 17'h18000);
    write_reg(REG_SIN, 17'h07FFF);
    write_reg(REG_CAMERA, 17'h1FFFF);
    write_reg(REG_FOCAL, 17'h1FF00);
    send_point('{16'sd12345, -16'sd32768, 16'sd32767});
    send_point('{-16'sd32768, 16'sd32767, -16'sd32768});
    drain_screens();
    write_reg(REG_FOCAL, 17'd1);
    write_reg(REG_CX, 17'd0);
    write_reg(REG_CY, 17'h1FFFF);
    send_point('{16'sd32767, 16'sd16384, -16'sd16384});
    send_point('{-16'sd1, -16'sd1, -16'sd1});
    drain_screens();
    write_reg(REG_COS, 17'd16384);
    write_reg(REG_SIN, 17'h1C000);
    write_reg(REG_CAMERA, 17'd49152);
    send_point('{16'sd8192, 16'sd16384, 16'sd0});
    send_point('{-16'sd8192, 16'sd0, 16'sd32767});
  endtask

  task automatic test_spare_index();
    drain_screens();
    write_reg(REG_SPARE_6, 17'h1FFFF);
    write_reg(REG_SPARE_7, 17'h15555);
    send_point('{16'sd1000, 16'sd2000, 16'sd3000});
    send_point('{-16'sd1000, -16'sd2000, -16'sd3000});
  endtask

  // long receiver hold-off against a sender that never idles
  task automatic test_backpressure();
    int i;
    drain_screens();
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 300;
    for (i = 0; i < 150; i++) send_point(random_point());
  endtask

  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        drain_screens();
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        randomize_config();
      end
      send_point(random_point());
    end
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      screen_ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else begin
      screen_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && screen_valid && screen_ready) begin
      if (pending_screens.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word x=%0d y=%0d valid=%0b", $time,
                 $signed(screen.screen_x), $signed(screen.screen_y), screen.proj_valid);
      end else begin
        want = pending_screens.pop_front();
        if (screen.screen_x !== want.screen_x) begin
          mismatch_count++;
          $display("%0t: screen_x expected %0d actual %0d", $time,
                   $signed(want.screen_x), $signed(screen.screen_x));
        end
        if (screen.screen_y !== want.screen_y) begin
          mismatch_count++;
          $display("%0t: screen_y expected %0d actual %0d", $time,
                   $signed(want.screen_y), $signed(screen.screen_y));
        end
        if (screen.proj_valid !== want.proj_valid) begin
          mismatch_count++;
          $display("%0t: proj_valid expected %0b actual %0b", $time,
                   want.proj_valid, screen.proj_valid);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst       <= 1'b0;
    idle_pct  = 15;
    stall_pct = 15;
    test_reset_defaults();
    test_depth_sign();
    test_saturation();
    test_register_extremes();
    test_spare_index();
    test_backpressure();
    test_random_traffic(0, 0, 400);
    test_random_traffic(87, 0, 400);
    test_random_traffic(0, 87, 400);
    test_random_traffic(15, 15, 400);
    drain_screens();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && pending_screens.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
